### src/stra_pkg.sv
// ----------------------------------------------------------------------------
// stra_pkg
// shared types and constants of the sequenced trace ring reader
// ----------------------------------------------------------------------------
`default_nettype none

package stra_pkg;

    localparam int TRACE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TRACE_DEPTH);
    localparam int CNT_W       = $clog2(TRACE_DEPTH + 1);
    localparam int COPIED_W    = 6;
    localparam int CAP_W       = 8;
    localparam int SEQ_W       = 32;

    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    localparam int RESQ_DEPTH  = 4;
    localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W  = $clog2(RESQ_DEPTH + 1);

    localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_RECORD  = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_CAP = 2'd1;
    localparam logic [1:0] STATUS_WINDOW  = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [15:0]      pc;
        logic [7:0]       event_code;
        logic [7:0]       result_code;
        logic [31:0]      value;
        logic [31:0]      elapsed_time;
        logic [31:0]      cursor;
        logic [CAP_W-1:0] capacity;
    } item_t;

    typedef struct packed {
        logic             is_summary;
        logic [31:0]      sequence_res;
        logic [15:0]      entry_pc;
        logic [7:0]       entry_event;
        logic [7:0]       entry_result;
        logic [31:0]      entry_value;
        logic [31:0]      entry_elapsed;
        logic [1:0]       status;
        logic [COPIED_W-1:0] copied;
        logic [31:0]      resume_cursor;
        logic [31:0]      dropped;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [15:0]      pc;
        logic [7:0]       ev;
        logic [7:0]       res;
        logic [31:0]      val;
        logic [31:0]      ela;
    } rec_t;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] copied;
        logic [1:0]       status;
        logic [31:0]      resume_cursor;
        logic [31:0]      dropped;
        rec_t             rec;
    } cmd_t;

endpackage

`default_nettype wire

### src/stra_front.sv
// ----------------------------------------------------------------------------
// stra_front
// accepts items, keeps head, count and sequence, turns records and reads
// into commands for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module stra_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire stra_pkg::item_t item,
    output logic                cmd_push,
    output stra_pkg::cmd_t      cmd
);
    import stra_pkg::*;

    logic [IDX_W-1:0] head_reg,   head_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [SEQ_W-1:0] seq_reg,    seq_next;
    logic [SEQ_W-1:0] latest_reg, latest_next;
    logic [SEQ_W-1:0] base_reg,   base_next;

    logic             seq_sat;
    logic             grow;
    logic             cap_bad;
    logic             ahead;
    logic             stale;
    logic [SEQ_W-1:0] avail_full;
    logic [CNT_W-1:0] avail;
    logic [CNT_W-1:0] cap_n;
    logic [CNT_W-1:0] copied;
    logic [IDX_W:0]   start_sum;
    logic [IDX_W-1:0] start_idx;

    assign seq_sat = (seq_reg == SEQ_MAX);
    assign grow    = (count_reg < CNT_W'(TRACE_DEPTH));

    // read classification
    assign cap_bad    = (item.capacity > CAP_W'(TRACE_DEPTH));
    assign ahead      = (item.cursor > latest_reg);
    assign stale      = (count_reg != '0) && (item.cursor < base_reg);
    assign avail_full = latest_reg - item.cursor;
    assign avail      = avail_full[CNT_W-1:0];
    assign cap_n      = item.capacity[CNT_W-1:0];
    assign copied     = (avail < cap_n) ? avail : cap_n;

    assign start_sum  = (IDX_W+1)'(head_reg) + (IDX_W+1)'(TRACE_DEPTH) - (IDX_W+1)'(avail);
    assign start_idx  = (start_sum >= (IDX_W+1)'(TRACE_DEPTH))
                        ? IDX_W'(start_sum - (IDX_W+1)'(TRACE_DEPTH))
                        : start_sum[IDX_W-1:0];

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        seq_next    = seq_reg;
        latest_next = latest_reg;
        base_next   = base_reg;
        cmd_push    = 1'b0;

        cmd               = '0;
        cmd.kind          = CMD_WRITE;
        cmd.idx           = head_reg;
        cmd.rec.seq       = seq_reg;
        cmd.rec.pc        = item.pc;
        cmd.rec.ev        = item.event_code;
        cmd.rec.res       = item.result_code;
        cmd.rec.val       = item.value;
        cmd.rec.ela       = item.elapsed_time;
        cmd.resume_cursor = item.cursor;

        if (accept)
        begin
            unique case (item.op)
                OP_CLEAR:
                begin
                    head_next   = '0;
                    count_next  = '0;
                    seq_next    = SEQ_W'(1);
                    latest_next = '0;
                    base_next   = '0;
                end
                OP_RECORD:
                begin
                    cmd_push  = 1'b1;
                    head_next = (head_reg == IDX_W'(TRACE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    if (grow)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (!seq_sat)
                    begin
                        seq_next    = seq_reg + 1'b1;
                        latest_next = latest_reg + 1'b1;
                    end
                    // base tracks latest minus count
                    if (grow && seq_sat)
                    begin
                        base_next = base_reg - 1'b1;
                    end
                    else if (!grow && !seq_sat)
                    begin
                        base_next = base_reg + 1'b1;
                    end
                end
                OP_READ:
                begin
                    cmd_push = 1'b1;
                    cmd.kind = CMD_READ;
                    priority if (cap_bad)
                    begin
                        cmd.status = STATUS_BAD_CAP;
                    end
                    else if (ahead)
                    begin
                        cmd.status        = STATUS_WINDOW;
                        cmd.resume_cursor = latest_reg;
                    end
                    else if (stale)
                    begin
                        cmd.status        = STATUS_WINDOW;
                        cmd.resume_cursor = base_reg;
                        cmd.dropped       = base_reg - item.cursor;
                    end
                    else
                    begin
                        cmd.status = STATUS_OK;
                        cmd.copied = copied;
                        cmd.idx    = start_idx;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            seq_reg    <= SEQ_W'(1);
            latest_reg <= '0;
            base_reg   <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            seq_reg    <= seq_next;
            latest_reg <= latest_next;
            base_reg   <= base_next;
        end
    end

endmodule

`default_nettype wire

### src/stra_cmd_queue.sv
// ----------------------------------------------------------------------------
// stra_cmd_queue
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

module stra_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire stra_pkg::cmd_t wr_data,
    output logic               q_full,
    input  wire logic          rd_en,
    output stra_pkg::cmd_t     rd_data,
    output logic               q_empty
);
    import stra_pkg::*;

    cmd_t                  q_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wptr_reg, wptr_next;
    logic [CMDQ_PTR_W-1:0] rptr_reg, rptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg,  cnt_next;

    assign q_full  = (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = q_mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (wr_en)
        begin
            wptr_next = (wptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rptr_next = (rptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### src/stra_back.sv
// ----------------------------------------------------------------------------
// stra_back
// trace store, read sequencer and result queue
// ----------------------------------------------------------------------------
`default_nettype none

module stra_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire stra_pkg::cmd_t  cmd,
    input  wire logic            cmd_empty,
    output logic                 cmd_pop,
    output stra_pkg::result_t    result,
    output logic                 empty,
    input  wire logic            pop
);
    import stra_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_SUM  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    rec_t             trace_mem [TRACE_DEPTH];
    rec_t             rdata_reg;

    logic [IDX_W-1:0] ridx_reg,   ridx_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [CNT_W-1:0] copied_reg, copied_next;
    logic [1:0]       status_reg, status_next;
    logic [31:0]      nc_reg,     nc_next;
    logic [31:0]      dropped_reg, dropped_next;
    logic             pend_reg;

    result_t               res_mem [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] res_wptr_reg, res_wptr_next;
    logic [RESQ_PTR_W-1:0] res_rptr_reg, res_rptr_next;
    logic [RESQ_CNT_W-1:0] res_cnt_reg,  res_cnt_next;

    logic          take_cmd;
    logic          mem_we;
    logic          issue;
    logic          push_sum;
    logic          res_push;
    logic          res_pop;
    logic [RESQ_CNT_W:0] room_used;
    result_t       res_data;

    assign take_cmd  = (state_reg == B_IDLE) && !cmd_empty;
    assign cmd_pop   = take_cmd;
    assign mem_we    = take_cmd && (cmd.kind == CMD_WRITE);
    assign room_used = (RESQ_CNT_W+1)'(res_cnt_reg) + (RESQ_CNT_W+1)'(pend_reg);
    assign issue     = (state_reg == B_READ) && (room_used < (RESQ_CNT_W+1)'(RESQ_DEPTH));
    assign push_sum  = (state_reg == B_SUM) && !pend_reg
                       && (res_cnt_reg < RESQ_CNT_W'(RESQ_DEPTH));
    assign res_push  = pend_reg || push_sum;
    assign res_pop   = pop && !empty;

    assign empty  = (res_cnt_reg == '0);
    assign result = res_mem[res_rptr_reg];

    always_comb
    begin
        res_data = '0;
        if (pend_reg)
        begin
            res_data.sequence_res  = rdata_reg.seq;
            res_data.entry_pc      = rdata_reg.pc;
            res_data.entry_event   = rdata_reg.ev;
            res_data.entry_result  = rdata_reg.res;
            res_data.entry_value   = rdata_reg.val;
            res_data.entry_elapsed = rdata_reg.ela;
        end
        else
        begin
            res_data.is_summary    = 1'b1;
            res_data.status        = status_reg;
            res_data.copied        = COPIED_W'(copied_reg);
            res_data.resume_cursor = nc_reg;
            res_data.dropped       = dropped_reg;
            res_data.last          = 1'b1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ridx_next    = ridx_reg;
        remain_next  = remain_reg;
        copied_next  = copied_reg;
        status_next  = status_reg;
        nc_next      = nc_reg;
        dropped_next = dropped_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (take_cmd && (cmd.kind == CMD_READ))
                begin
                    ridx_next    = cmd.idx;
                    remain_next  = cmd.copied;
                    copied_next  = cmd.copied;
                    status_next  = cmd.status;
                    nc_next      = cmd.resume_cursor;
                    dropped_next = cmd.dropped;
                    state_next   = (cmd.copied == '0) ? B_SUM : B_READ;
                end
            end
            B_READ:
            begin
                if (issue)
                begin
                    ridx_next   = (ridx_reg == IDX_W'(TRACE_DEPTH - 1)) ? '0 : ridx_reg + 1'b1;
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = B_SUM;
                    end
                end
            end
            B_SUM:
            begin
                if (push_sum)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // summary cursor follows the last entry delivered
        if (pend_reg)
        begin
            nc_next = rdata_reg.seq;
        end
    end

    always_comb
    begin
        res_wptr_next = res_wptr_reg;
        res_rptr_next = res_rptr_reg;
        res_cnt_next  = res_cnt_reg;
        if (res_push)
        begin
            res_wptr_next = (res_wptr_reg == RESQ_PTR_W'(RESQ_DEPTH - 1))
                            ? '0 : res_wptr_reg + 1'b1;
        end
        if (res_pop)
        begin
            res_rptr_next = (res_rptr_reg == RESQ_PTR_W'(RESQ_DEPTH - 1))
                            ? '0 : res_rptr_reg + 1'b1;
        end
        if (res_push && !res_pop)
        begin
            res_cnt_next = res_cnt_reg + 1'b1;
        end
        else if (!res_push && res_pop)
        begin
            res_cnt_next = res_cnt_reg - 1'b1;
        end
    end

    // trace store with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            trace_mem[cmd.idx] <= cmd.rec;
        end
        if (issue)
        begin
            rdata_reg <= trace_mem[ridx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem[res_wptr_reg] <= res_data;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg    <= ridx_next;
        copied_reg  <= copied_next;
        status_reg  <= status_next;
        nc_reg      <= nc_next;
        dropped_reg <= dropped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            remain_reg   <= '0;
            pend_reg     <= 1'b0;
            res_wptr_reg <= '0;
            res_rptr_reg <= '0;
            res_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            remain_reg   <= remain_next;
            pend_reg     <= issue;
            res_wptr_reg <= res_wptr_next;
            res_rptr_reg <= res_rptr_next;
            res_cnt_reg  <= res_cnt_next;
        end
    end

endmodule

`default_nettype wire

### src/sequenced_trace_ring_reader.sv
// ----------------------------------------------------------------------------
// sequenced_trace_ring_reader
// circular trace store of sequenced records with a cursor based reader
//
// input side is a queue: an item beat is taken when push is high and full is
// low. op clear resets head, count and sequence (sequence restarts at 1, as
// after reset); op record stores one entry; op read streams, oldest first,
// the entries newer than cursor up to capacity, then one summary beat with
// last set. result side is a queue: the oldest result sits on result while
// empty is low and leaves when pop is high.
// clear and record items are taken one per cycle while full is low. records
// and reads pass a four deep command queue to the back end, which reads the
// trace store one entry per cycle through its single registered read port
// while the result queue has room. the first entry beat of a read passes
// the command queue, the back end's registered read and the result queue
// before it is on result, and the summary follows the last entry.
// when the receiver stops popping, the four entry result queue fills, the
// back end pauses, the command queue fills and full rises; nothing is lost.
// reset empties both queues and the trace; store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sequenced_trace_ring_reader (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire stra_pkg::item_t  item,
    output logic                  empty,
    input  wire logic             pop,
    output stra_pkg::result_t     result
);
    import stra_pkg::*;

    logic accept;
    logic cmd_push;
    cmd_t cmd_in;
    cmd_t cmd_out;
    logic cmd_empty;
    logic cmd_pop;

    assign accept = push && !full;

    stra_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    stra_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .q_full  (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .q_empty (cmd_empty)
    );

    stra_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sequenced trace ring reader
//
// a driver feeds item beats from a backlog that the stimulus block fills; a
// monitor predicts every accepted beat against its own copy of the trace
// ring and compares each popped result beat with the oldest prediction.
// directed beats cover empty reads, field extremes, bad capacity, cursor
// ahead, clear and the ignored op; random beats are mostly record bursts and
// reads with cursors in, behind and ahead of the window, in three idle mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import stra_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        item_t beat;
        bit    wait_idle;
    } stim_t;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    pop   = 1'b0;
    item_t   item  = '0;
    logic    full;
    logic    empty;
    result_t result;

    stim_t   stim_backlog[$];
    result_t pending_results[$];

    int      send_idle_pct = 29;
    int      recv_idle_pct = 45;
    int      mismatches    = 0;
    int      cycle_count   = 0;
    logic    took_item     = 1'b0;
    bit      hold_next     = 1'b0;

    // predictor state
    rec_t             ring_copy [TRACE_DEPTH];
    logic [IDX_W-1:0] ring_head     = '0;
    logic [CNT_W-1:0] ring_count    = '0;
    logic [SEQ_W-1:0] ring_next_seq = 1;

    // stimulus-side view of the sequence window
    int unsigned gen_next_seq = 1;
    int unsigned gen_count    = 0;

    sequenced_trace_ring_reader u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t summary_beat(logic [1:0] st, logic [COPIED_W-1:0] cp,
                                             logic [31:0] nc, logic [31:0] dr);
        result_t s;
        s               = '0;
        s.is_summary    = 1'b1;
        s.last          = 1'b1;
        s.status        = st;
        s.copied        = cp;
        s.resume_cursor = nc;
        s.dropped       = dr;
        return s;
    endfunction

    task automatic predict_beat(item_t b);
        result_t          e;
        logic [31:0]      latest;
        logic [31:0]      oldest;
        logic [31:0]      avail;
        logic [31:0]      n_copy;
        logic [31:0]      seq;
        logic [31:0]      nc;
        logic [IDX_W-1:0] idx;
        case (b.op)
            OP_CLEAR:
            begin
                ring_head     = '0;
                ring_count    = '0;
                ring_next_seq = 1;
            end
            OP_RECORD:
            begin
                ring_copy[ring_head] = '{seq: ring_next_seq, pc: b.pc, ev: b.event_code,
                                         res: b.result_code, val: b.value,
                                         ela: b.elapsed_time};
                ring_head = IDX_W'((int'(ring_head) + 1) % TRACE_DEPTH);
                if (ring_count < TRACE_DEPTH)
                    ring_count = ring_count + 1'b1;
                if (ring_next_seq != SEQ_MAX)
                    ring_next_seq = ring_next_seq + 1;
            end
            OP_READ:
            begin
                latest = (ring_next_seq == 0) ? 32'd0 : ring_next_seq - 1;
                oldest = (ring_count == 0) ? latest + 1 : latest - ring_count + 1;
                if (b.capacity > TRACE_DEPTH)
                    pending_results.push_back(summary_beat(STATUS_BAD_CAP, '0, b.cursor, '0));
                else if (b.cursor > latest)
                    pending_results.push_back(summary_beat(STATUS_WINDOW, '0, latest, '0));
                else if (ring_count != 0 && b.cursor < oldest - 1)
                    pending_results.push_back(summary_beat(STATUS_WINDOW, '0, oldest - 1,
                                                           oldest - 1 - b.cursor));
                else
                begin
                    avail  = latest - b.cursor;
                    n_copy = (avail < b.capacity) ? avail : 32'(b.capacity);
                    nc     = b.cursor;
                    for (int i = 0; i < int'(n_copy); i++)
                    begin
                        seq = b.cursor + i + 1;
                        idx = IDX_W'((int'(ring_head) + TRACE_DEPTH - int'(ring_count)
                                      + int'(seq - oldest)) % TRACE_DEPTH);
                        e               = '0;
                        e.sequence_res  = ring_copy[idx].seq;
                        e.entry_pc      = ring_copy[idx].pc;
                        e.entry_event   = ring_copy[idx].ev;
                        e.entry_result  = ring_copy[idx].res;
                        e.entry_value   = ring_copy[idx].val;
                        e.entry_elapsed = ring_copy[idx].ela;
                        pending_results.push_back(e);
                        nc = ring_copy[idx].seq;
                    end
                    pending_results.push_back(summary_beat(STATUS_OK, COPIED_W'(n_copy),
                                                           nc, '0));
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // monitor and predictor
    always @(posedge clk)
    begin : monitor
        result_t want;
        cycle_count++;
        if (rst_n && !empty && pop)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("is_summary",    want.is_summary,    result.is_summary);
                check_field("sequence_res",  want.sequence_res,  result.sequence_res);
                check_field("entry_pc",      want.entry_pc,      result.entry_pc);
                check_field("entry_event",   want.entry_event,   result.entry_event);
                check_field("entry_result",  want.entry_result,  result.entry_result);
                check_field("entry_value",   want.entry_value,   result.entry_value);
                check_field("entry_elapsed", want.entry_elapsed, result.entry_elapsed);
                check_field("status",        want.status,        result.status);
                check_field("copied",        want.copied,        result.copied);
                check_field("resume_cursor", want.resume_cursor, result.resume_cursor);
                check_field("dropped",       want.dropped,       result.dropped);
                check_field("last",          want.last,          result.last);
            end
        end
        if (rst_n && push && !full)
            predict_beat(item);
        took_item <= rst_n && push && !full;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!push || took_item)
            begin
                if (stim_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct
                    && !(stim_backlog[0].wait_idle && pending_results.size() != 0))
                begin
                    item <= stim_backlog[0].beat;
                    push <= 1'b1;
                    void'(stim_backlog.pop_front());
                end
                else
                    push <= 1'b0;
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic enqueue(item_t b);
        stim_backlog.push_back('{beat: b, wait_idle: hold_next});
        hold_next = 1'b0;
    endtask

    task automatic queue_record(logic [15:0] pc, logic [7:0] ev, logic [7:0] res,
                                logic [31:0] val, logic [31:0] ela);
        item_t b;
        b              = '0;
        b.op           = OP_RECORD;
        b.pc           = pc;
        b.event_code   = ev;
        b.result_code  = res;
        b.value        = val;
        b.elapsed_time = ela;
        enqueue(b);
        if (gen_count < TRACE_DEPTH)
            gen_count++;
        gen_next_seq++;
    endtask

    task automatic queue_random_record();
        queue_record(16'($urandom()), 8'($urandom()), 8'($urandom()), $urandom(), $urandom());
    endtask

    task automatic queue_read(logic [31:0] cursor, logic [7:0] cap);
        item_t b;
        b          = '0;
        b.op       = OP_READ;
        b.cursor   = cursor;
        b.capacity = cap;
        enqueue(b);
    endtask

    task automatic queue_clear();
        item_t b;
        b    = '0;
        b.op = OP_CLEAR;
        enqueue(b);
        gen_count    = 0;
        gen_next_seq = 1;
    endtask

    task automatic queue_unused_op(bit all_ones);
        item_t b;
        b    = all_ones ? '1 : item_t'({$urandom(), $urandom(), $urandom(), $urandom(),
                                          $urandom()});
        b.op = OP_IGNORED;
        enqueue(b);
    endtask

    task automatic queue_random_read();
        int unsigned latest;
        int unsigned behind;
        logic [31:0] cursor;
        logic [7:0]  cap;
        int          pick;
        latest = gen_next_seq - 1;
        behind = latest - gen_count;
        pick   = $urandom_range(99);
        if (pick < 15 && behind > 0)
            cursor = $urandom_range(behind - 1, 0);
        else if (pick < 30)
            cursor = latest + 1 + $urandom_range(3, 0);
        else if (pick < 38)
            cursor = $urandom();
        else
            cursor = latest - $urandom_range(gen_count, 0);
        pick = $urandom_range(99);
        if (pick < 55)
            cap = 8'($urandom_range(TRACE_DEPTH, 0));
        else if (pick < 75)
            cap = 8'(TRACE_DEPTH);
        else if (pick < 85)
            cap = 8'($urandom_range(4, 1));
        else
            cap = 8'($urandom_range(255, TRACE_DEPTH + 1));
        queue_read(cursor, cap);
    endtask

    task automatic queue_random_mix(int n_items, bit long_burst);
        int n;
        int pick;
        n         = 0;
        hold_next = 1'b1;
        if (long_burst)
        begin
            for (int i = 0; i < TRACE_DEPTH + 6; i++)
                queue_random_record();
            queue_read(0, 8'(TRACE_DEPTH));
            queue_read(gen_next_seq - 1 - TRACE_DEPTH, 8'(TRACE_DEPTH));
            n = TRACE_DEPTH + 8;
        end
        while (n < n_items)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 3)
                hold_next = 1'b1;
            if (pick < 6)
            begin
                queue_clear();
                n++;
            end
            else if (pick < 11)
                queue_unused_op(1'b0);
            else if (pick < 64)
            begin
                for (int i = $urandom_range(6, 1); i > 0; i--)
                begin
                    queue_random_record();
                    n++;
                end
            end
            else
            begin
                queue_random_read();
                n++;
            end
        end
    endtask

    task automatic wait_drained();
        while (stim_backlog.size() != 0 || push || pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed
        queue_read(0, 0);
        queue_read(0, 8'(TRACE_DEPTH));
        queue_read(7, 5);
        queue_read(0, 8'(TRACE_DEPTH + 1));
        queue_read('1, '1);
        queue_record('0, '0, '0, '0, '0);
        queue_record('1, '1, '1, '1, '1);
        queue_record(16'h5555, 8'hAA, 8'h55, 32'hAAAA_AAAA, 32'h5555_5555);
        queue_record(16'hAAAA, 8'h55, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_read(0, 8'(TRACE_DEPTH));
        queue_read(1, 2);
        queue_read(0, 0);
        queue_read(4, 8);
        queue_read(5, 1);
        queue_unused_op(1'b1);
        queue_clear();
        queue_read(0, 4);
        queue_random_record();
        queue_read(0, 1);

        send_idle_pct = 29;
        recv_idle_pct = 45;
        queue_random_mix(40, 1'b1);
        wait_drained();

        send_idle_pct = 45;
        recv_idle_pct = 29;
        queue_random_mix(25, 1'b0);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_mix(25, 1'b0);
        wait_drained();

        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
